// File: rtl/dbd_pkg.sv
// Package for the detector raw byte deframer: parser state codes, marker
// bytes and the result type.
// No dependencies.
`default_nettype none

package dbd_pkg;

   typedef logic [6:0] state_type;

   // Parser state codes
   localparam state_type ST_READY      = 7'd0;
   localparam state_type ST_ERROR      = 7'd1;
   localparam state_type ST_PRE0       = 7'd2;
   localparam state_type ST_PRE1       = 7'd3;
   localparam state_type ST_HDR0       = 7'd4;
   localparam state_type ST_HDR1       = 7'd5;
   localparam state_type ST_HDR2       = 7'd6;
   localparam state_type ST_HDR3       = 7'd7;
   localparam state_type ST_HDR14      = 7'd18;
   localparam state_type ST_WORD_FIRST = 7'd19;
   localparam state_type ST_WORD_LAST  = 7'd54;
   localparam state_type ST_BYTE_FIRST = 7'd55;
   localparam state_type ST_BYTE_LAST  = 7'd66;
   localparam state_type ST_HDR63      = 7'd67;
   localparam state_type ST_FRAME0     = 7'd68;
   localparam state_type ST_FRAME2     = 7'd70;
   localparam state_type ST_FRAME3     = 7'd71;
   localparam state_type ST_FRAME6     = 7'd74;
   localparam state_type ST_FRAME7     = 7'd75;
   localparam state_type ST_HIT0       = 7'd76;
   localparam state_type ST_HIT2       = 7'd78;
   localparam state_type ST_HIT3       = 7'd79;
   localparam state_type ST_HIT4       = 7'd80;
   localparam state_type ST_HIT6       = 7'd82;
   localparam state_type ST_HIT7       = 7'd83;
   localparam state_type ST_END        = 7'd84;

   // Marker bytes
   localparam logic [7:0] MK_SYNC  = 8'hEE;
   localparam logic [7:0] MK_B1    = 8'h12;
   localparam logic [7:0] MK_B2    = 8'h34;
   localparam logic [7:0] MK_FRAME = 8'hAA;
   localparam logic [7:0] MK_END   = 8'h00;

   localparam logic [31:0] HDR_COUNT_START = 32'd16;

   typedef struct packed {
      logic [31:0] byte_count;
      logic        word_done;
      logic        error_flag;
      state_type   parser_state;
      logic [31:0] field_value;
   } result_type;

endpackage

`default_nettype wire

// File: rtl/detector_raw_byte_deframer_unit.sv
// Top level of the detector raw byte deframer: input byte register,
// parser step and result register. Uses dbd_pkg and dbd_parser.
//
//   channel  | dir | tdata fields (low bit up)
//   req_*    | in  | data_byte[7:0]
//   rsp_*    | out | field_value[31:0] parser_state[38:32] error_flag[39]
//            |     | word_done[40] byte_count[72:41], zero [79:73]
//
// One byte per cycle sustained while the result side does not stall; a byte
// taken into the input byte register is stepped into the result register, which then offers its beat.
// The parser state, value word and byte count advance once per byte,
// combinationally between the two registers.
// Synchronous reset returns the parser to ready with zero word and count.
// A stalled result holds; a new byte is still taken while the result is
// consumed in the same cycle.
`default_nettype none

module detector_raw_byte_deframer_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // data_byte
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [79:0] rsp_tdata    // field_value, parser_state, error_flag,
                                         // word_done, byte_count, zero pad
);

   logic                in_valid_ff;
   logic [7:0]          in_byte_ff;
   logic                out_valid_ff;
   dbd_pkg::result_type out_ff;
   dbd_pkg::result_type step_result;
   logic                advance;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   dbd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .data_byte (in_byte_ff),
      .result    (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= step_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_ff};

`ifndef SYNTHESIS
   // a held input byte must not change while the result side stalls
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff))
      else $error("input byte lost or changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_tready |=> out_valid_ff && $stable(out_ff))
      else $error("result register changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("parser step did not produce a result beat");

   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.parser_state == dbd_pkg::ST_ERROR
      |-> out_ff.error_flag && !out_ff.word_done)
      else $error("error state beat with inconsistent flags");
`endif

endmodule

`default_nettype wire

// File: rtl/dbd_parser.sv
// Byte parser of the deframer: state code, value word and byte count,
// advanced by one byte per step. Uses dbd_pkg.
`default_nettype none

module dbd_parser (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step,
   input  wire logic [7:0]         data_byte,
   output dbd_pkg::result_type     result
);

   dbd_pkg::state_type state_ff, state_in;
   logic [31:0]        acc_ff, acc_in;
   logic [31:0]        cnt_ff, cnt_in;

   logic               lane_en;
   logic               lane_start;
   logic [1:0]         lane_pos;
   logic               byte_load;
   logic               cnt_load;
   logic               add4;
   logic               done;
   logic [31:0]        lane_base;
   logic [32:0]        cnt_sum;
   dbd_pkg::state_type s_next;

   always_comb begin
      state_in   = dbd_pkg::ST_READY;
      lane_en    = 1'b0;
      lane_start = 1'b0;
      lane_pos   = 2'd0;
      byte_load  = 1'b0;
      cnt_load   = 1'b0;
      add4       = 1'b0;
      s_next     = state_ff + 7'd1;

      priority if (state_ff == dbd_pkg::ST_READY || state_ff == dbd_pkg::ST_END) begin
         state_in = (data_byte == dbd_pkg::MK_SYNC) ? dbd_pkg::ST_PRE0 : dbd_pkg::ST_READY;
      end else if (state_ff == dbd_pkg::ST_PRE0) begin
         state_in = (data_byte == dbd_pkg::MK_B1) ? dbd_pkg::ST_PRE1 : dbd_pkg::ST_READY;
      end else if (state_ff == dbd_pkg::ST_PRE1) begin
         state_in = (data_byte == dbd_pkg::MK_B2) ? dbd_pkg::ST_HDR2 : dbd_pkg::ST_ERROR;
      end else if (state_ff == dbd_pkg::ST_HDR0) begin
         state_in = (data_byte == dbd_pkg::MK_B1) ? dbd_pkg::ST_HDR1 : dbd_pkg::ST_ERROR;
      end else if (state_ff == dbd_pkg::ST_HDR1) begin
         state_in = (data_byte == dbd_pkg::MK_B2) ? dbd_pkg::ST_HDR2 : dbd_pkg::ST_ERROR;
      end else if (state_ff == dbd_pkg::ST_HDR2) begin
         state_in = (data_byte == dbd_pkg::MK_SYNC) ? dbd_pkg::ST_HDR3 : dbd_pkg::ST_ERROR;
      end else if (state_ff >= dbd_pkg::ST_HDR3 && state_ff <= dbd_pkg::ST_HDR14) begin
         byte_load = 1'b1;
         cnt_load  = (state_ff == dbd_pkg::ST_HDR14);
         state_in  = s_next;
      end else if (state_ff >= dbd_pkg::ST_WORD_FIRST && state_ff <= dbd_pkg::ST_WORD_LAST) begin
         lane_en    = 1'b1;
         lane_pos   = 2'(state_ff - dbd_pkg::ST_WORD_FIRST);
         lane_start = (lane_pos == 2'd0);
         state_in   = s_next;
      end else if (state_ff >= dbd_pkg::ST_BYTE_FIRST && state_ff <= dbd_pkg::ST_BYTE_LAST) begin
         byte_load = 1'b1;
         add4      = (2'(state_ff - dbd_pkg::ST_BYTE_FIRST) == 2'd3);
         state_in  = s_next;
      end else if (state_ff == dbd_pkg::ST_HDR63) begin
         state_in = (data_byte == dbd_pkg::MK_FRAME) ? dbd_pkg::ST_FRAME0 : dbd_pkg::ST_ERROR;
      end else if (state_ff >= dbd_pkg::ST_FRAME0 && state_ff <= dbd_pkg::ST_FRAME2) begin
         // marker byte took lane 0, so the word fills lanes 1 to 3
         lane_en    = 1'b1;
         lane_pos   = 2'(state_ff - dbd_pkg::ST_HDR63);
         lane_start = (state_ff == dbd_pkg::ST_FRAME0);
         state_in   = s_next;
      end else if (state_ff >= dbd_pkg::ST_FRAME3 && state_ff <= dbd_pkg::ST_FRAME6) begin
         lane_en    = 1'b1;
         lane_pos   = 2'(state_ff - dbd_pkg::ST_FRAME3);
         lane_start = (lane_pos == 2'd0);
         state_in   = s_next;
      end else if (state_ff == dbd_pkg::ST_FRAME7 || state_ff == dbd_pkg::ST_HIT7) begin
         byte_load = 1'b1;
         priority if (data_byte == dbd_pkg::MK_FRAME) begin
            state_in = dbd_pkg::ST_FRAME0;
         end else if (data_byte == dbd_pkg::MK_SYNC) begin
            state_in = dbd_pkg::ST_HDR0;
         end else if (data_byte == dbd_pkg::MK_END) begin
            state_in = dbd_pkg::ST_END;
         end else begin
            state_in = dbd_pkg::ST_HIT0;
         end
      end else if (state_ff >= dbd_pkg::ST_HIT0 && state_ff <= dbd_pkg::ST_HIT2) begin
         lane_en    = 1'b1;
         lane_pos   = 2'(state_ff - dbd_pkg::ST_FRAME7);
         lane_start = (state_ff == dbd_pkg::ST_HIT0);
         state_in   = s_next;
      end else if (state_ff == dbd_pkg::ST_HIT3) begin
         byte_load = 1'b1;
         state_in  = s_next;
      end else if (state_ff >= dbd_pkg::ST_HIT4 && state_ff <= dbd_pkg::ST_HIT6) begin
         lane_en    = 1'b1;
         lane_pos   = 2'(state_ff - dbd_pkg::ST_HIT3);
         lane_start = (state_ff == dbd_pkg::ST_HIT4);
         state_in   = s_next;
      end else begin
         // error and unused codes: drop the byte
         state_in = dbd_pkg::ST_READY;
      end
   end

   // Big-endian lane insert into the value word
   always_comb begin
      lane_base = lane_start ? 32'd0 : acc_ff;
      acc_in    = acc_ff;
      done      = 1'b0;
      if (byte_load) begin
         acc_in = {24'd0, data_byte};
      end else if (lane_en) begin
         unique case (lane_pos)
            2'd0: acc_in = {data_byte, lane_base[23:0]};
            2'd1: acc_in = {lane_base[31:24], data_byte, lane_base[15:0]};
            2'd2: acc_in = {lane_base[31:16], data_byte, lane_base[7:0]};
            2'd3: acc_in = {lane_base[31:8], data_byte};
            default: acc_in = acc_ff;
         endcase
         done = (lane_pos == 2'd3);
      end
   end

   // Saturating byte count
   always_comb begin
      cnt_sum = {1'b0, cnt_ff} + 33'd4;
      cnt_in  = cnt_ff;
      if (cnt_load) begin
         cnt_in = dbd_pkg::HDR_COUNT_START;
      end else if (add4 || done) begin
         cnt_in = cnt_sum[32] ? 32'hFFFF_FFFF : cnt_sum[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dbd_pkg::ST_READY;
         acc_ff   <= 32'd0;
         cnt_ff   <= 32'd0;
      end else if (step) begin
         state_ff <= state_in;
         acc_ff   <= acc_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign result.field_value  = acc_in;
   assign result.parser_state = state_in;
   assign result.error_flag   = (state_in == dbd_pkg::ST_ERROR);
   assign result.word_done    = done;
   assign result.byte_count   = cnt_in;

endmodule

`default_nettype wire
